### rtl/rbf_pkg.sv
// shared types, constants and the border index mapping for the rgb box filter
// no dependencies
package rbf_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MAX_RADIUS_DEF = 16;

    localparam int DIM_BITS   = 11;
    localparam int RAD_BITS   = 5;
    localparam int MODE_BITS  = 2;
    localparam int CRD_BITS   = 13;
    localparam int DLT_BITS   = 7;
    localparam int POS_BITS   = 23;
    localparam int SUM_BITS   = 20;
    localparam int AREA_BITS  = 12;
    localparam int DVD_BITS   = 28;
    localparam int CNT_BITS   = 5;
    localparam int CHAN_BITS  = 8;
    localparam int PIX_BITS   = 24;
    localparam int MEAN_BITS  = 16;
    localparam int OPOS_BITS  = 10;
    localparam int PADDR_BITS = 4;
    localparam int PDATA_BITS = 32;

    localparam logic [MODE_BITS-1:0] MODE_REPLICATE = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_REFLECT   = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_ZERO      = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;
    localparam logic [1:0] REG_MODE   = 2'd3;

    localparam logic CMD_PIXEL = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_LOAD,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic [DIM_BITS-1:0]  width;
        logic [DIM_BITS-1:0]  height;
        logic [RAD_BITS-1:0]  radius;
        logic [MODE_BITS-1:0] mode;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic scan_run;
        logic div_load;
        logic div_run;
        logic out_done;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic scan_last;
        logic div_last;
    } status_t;

    typedef struct packed {
        logic [CRD_BITS-1:0] idx;
        logic                keep;
    } map_t;

    // border rule: replicate, reflect-101 then clamp, or zero fill
    function automatic map_t map_index(input logic signed [CRD_BITS-1:0] v,
                                       input logic [CRD_BITS-1:0] n,
                                       input logic [MODE_BITS-1:0] mode);
        logic signed [CRD_BITS-1:0] t;
        logic signed [CRD_BITS-1:0] top;
        map_t m;
        top    = signed'(n) - CRD_BITS'(1);
        t      = v;
        m.keep = 1'b1;
        m.idx  = '0;
        if (v >= 0 && v <= top) begin
            m.idx = unsigned'(v);
        end
        else if (mode == MODE_ZERO) begin
            m.keep = 1'b0;
        end
        else begin
            if (mode == MODE_REFLECT) begin
                if (v < 0) begin
                    t = -v;
                end
                else begin
                    t = top + top - v;
                end
            end
            if (t < 0) begin
                t = '0;
            end
            if (t > top) begin
                t = top;
            end
            m.idx = unsigned'(t);
        end
        return m;
    endfunction

endpackage

### rtl/rbf_cfg.sv
// configuration registers behind the apb-style port
// depends on rbf_pkg
module rbf_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rbf_pkg::PADDR_BITS-1:0] paddr,
    input  logic [rbf_pkg::PDATA_BITS-1:0] pwdata,
    output logic [rbf_pkg::PDATA_BITS-1:0] prdata,
    output logic                           pready,
    output rbf_pkg::cfg_t                  cfg,
    output logic                           restart
);

    rbf_pkg::cfg_t cfg_reg;
    logic [1:0]    index;
    logic          wr_en;

    assign index   = paddr[3:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign restart = wr_en;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= rbf_pkg::DIM_BITS'(512);
            cfg_reg.height <= rbf_pkg::DIM_BITS'(512);
            cfg_reg.radius <= rbf_pkg::RAD_BITS'(3);
            cfg_reg.mode   <= rbf_pkg::MODE_REFLECT;
        end
        else if (wr_en)
        begin
            unique case (index)
                rbf_pkg::REG_WIDTH:  cfg_reg.width  <= pwdata[rbf_pkg::DIM_BITS-1:0];
                rbf_pkg::REG_HEIGHT: cfg_reg.height <= pwdata[rbf_pkg::DIM_BITS-1:0];
                rbf_pkg::REG_RADIUS: cfg_reg.radius <= pwdata[rbf_pkg::RAD_BITS-1:0];
                rbf_pkg::REG_MODE:   cfg_reg.mode   <= pwdata[rbf_pkg::MODE_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            rbf_pkg::REG_WIDTH:  prdata = rbf_pkg::PDATA_BITS'(cfg_reg.width);
            rbf_pkg::REG_HEIGHT: prdata = rbf_pkg::PDATA_BITS'(cfg_reg.height);
            rbf_pkg::REG_RADIUS: prdata = rbf_pkg::PDATA_BITS'(cfg_reg.radius);
            rbf_pkg::REG_MODE:   prdata = rbf_pkg::PDATA_BITS'(cfg_reg.mode);
        endcase
    end

endmodule

### rtl/rbf_ctrl.sv
// sequencer: accept, window scan, divide, result handoff
// depends on rbf_pkg
module rbf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  rbf_pkg::status_t  status,
    output rbf_pkg::cmd_t     cmd
);

    rbf_pkg::state_t state_reg;
    rbf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rbf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            rbf_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.emit)
                    begin
                        state_next = rbf_pkg::ST_SCAN;
                    end
                end
            end
            rbf_pkg::ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (status.scan_last)
                begin
                    state_next = rbf_pkg::ST_FLUSH;
                end
            end
            rbf_pkg::ST_FLUSH:
            begin
                state_next = rbf_pkg::ST_LOAD;
            end
            rbf_pkg::ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = rbf_pkg::ST_DIVIDE;
            end
            rbf_pkg::ST_DIVIDE:
            begin
                cmd.div_run = 1'b1;
                if (status.div_last)
                begin
                    state_next = rbf_pkg::ST_OUTPUT;
                end
            end
            rbf_pkg::ST_OUTPUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    cmd.out_done = 1'b1;
                    state_next   = rbf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rbf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/rbf_datapath.sv
// line store, position counters, window accumulators and mean dividers
// depends on rbf_pkg
module rbf_datapath #(
    parameter int MAX_WIDTH  = rbf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rbf_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS = rbf_pkg::MAX_RADIUS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rbf_pkg::cfg_t                 cfg,
    input  logic                          restart,
    input  rbf_pkg::cmd_t                 cmd,
    output rbf_pkg::status_t              status,
    input  logic                          command,
    input  logic [rbf_pkg::CHAN_BITS-1:0] red_in,
    input  logic [rbf_pkg::CHAN_BITS-1:0] green_in,
    input  logic [rbf_pkg::CHAN_BITS-1:0] blue_in,
    output logic [rbf_pkg::MEAN_BITS-1:0] red_mean,
    output logic [rbf_pkg::MEAN_BITS-1:0] green_mean,
    output logic [rbf_pkg::MEAN_BITS-1:0] blue_mean,
    output logic [rbf_pkg::OPOS_BITS-1:0] out_column,
    output logic [rbf_pkg::OPOS_BITS-1:0] out_row,
    output logic                          frame_last
);

    localparam int DIM  = rbf_pkg::DIM_BITS;
    localparam int CRD  = rbf_pkg::CRD_BITS;
    localparam int DLT  = rbf_pkg::DLT_BITS;
    localparam int POS  = rbf_pkg::POS_BITS;
    localparam int SUMB = rbf_pkg::SUM_BITS;
    localparam int AREB = rbf_pkg::AREA_BITS;
    localparam int DVD  = rbf_pkg::DVD_BITS;
    localparam int CNT  = rbf_pkg::CNT_BITS;
    localparam int CH   = rbf_pkg::CHAN_BITS;
    // the ring holds a power of two rows, at least one full window high
    localparam int ROW_BITS  = $clog2(2 * MAX_RADIUS + 1);
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int ADR_BITS  = ROW_BITS + COL_BITS;
    localparam int DEPTH     = 1 << ADR_BITS;

    // effective frame size and radius
    logic [DIM-1:0]                w_eff, h_eff;
    logic [rbf_pkg::RAD_BITS-1:0]  r_eff;
    logic [POS-1:0]                delay;
    logic [5:0]                    side;
    logic [AREB-1:0]               area;

    always_comb
    begin
        if (cfg.width == '0)
        begin
            w_eff = DIM'(1);
        end
        else if (CRD'(cfg.width) > CRD'(MAX_WIDTH))
        begin
            w_eff = DIM'(MAX_WIDTH);
        end
        else
        begin
            w_eff = cfg.width;
        end
        if (cfg.height == '0)
        begin
            h_eff = DIM'(1);
        end
        else if (CRD'(cfg.height) > CRD'(MAX_HEIGHT))
        begin
            h_eff = DIM'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = cfg.height;
        end
        if (DLT'(cfg.radius) > DLT'(MAX_RADIUS))
        begin
            r_eff = rbf_pkg::RAD_BITS'(MAX_RADIUS);
        end
        else
        begin
            r_eff = cfg.radius;
        end
    end

    assign delay = POS'(r_eff) * POS'(w_eff) + POS'(r_eff);
    assign side  = {r_eff, 1'b1};
    assign area  = AREB'(side) * AREB'(side);

    // position counters
    logic [DIM-1:0] in_col_reg, in_row_reg, oc_reg, or_reg;
    logic [POS-1:0] in_pos_reg, out_pos_reg;
    logic           pixel_wr;
    logic           last;

    assign pixel_wr = (command == rbf_pkg::CMD_PIXEL) && (in_row_reg < h_eff);
    assign last     = (CRD'(or_reg) + CRD'(1) >= CRD'(h_eff))
                   && (CRD'(oc_reg) + CRD'(1) >= CRD'(w_eff));

    assign status.emit = pixel_wr
                       ? ((or_reg < h_eff) && (out_pos_reg + delay <= in_pos_reg))
                       : ((in_row_reg >= h_eff) && (or_reg < h_eff));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            oc_reg      <= '0;
            or_reg      <= '0;
            in_pos_reg  <= '0;
            out_pos_reg <= '0;
        end
        else if (restart || (cmd.out_done && last))
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            oc_reg      <= '0;
            or_reg      <= '0;
            in_pos_reg  <= '0;
            out_pos_reg <= '0;
        end
        else
        begin
            if (cmd.accept && pixel_wr)
            begin
                in_pos_reg <= in_pos_reg + POS'(1);
                if (in_col_reg + DIM'(1) >= w_eff)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + DIM'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + DIM'(1);
                end
            end
            if (cmd.out_done)
            begin
                out_pos_reg <= out_pos_reg + POS'(1);
                if (oc_reg + DIM'(1) >= w_eff)
                begin
                    oc_reg <= '0;
                    or_reg <= or_reg + DIM'(1);
                end
                else
                begin
                    oc_reg <= oc_reg + DIM'(1);
                end
            end
        end
    end

    // window scan counters
    logic signed [DLT-1:0] dy_reg, dx_reg, r_pos, r_neg;
    rbf_pkg::map_t         ym, xm;
    logic signed [CRD-1:0] yv, xv;
    logic [CRD-1:0]        in_col_x, in_row_x;
    logic [ADR_BITS-1:0]   wr_addr, rd_addr;

    assign r_pos = signed'(DLT'(r_eff));
    assign r_neg = -r_pos;
    assign yv    = signed'(CRD'(or_reg)) + CRD'(dy_reg);
    assign xv    = signed'(CRD'(oc_reg)) + CRD'(dx_reg);
    assign ym    = rbf_pkg::map_index(yv, CRD'(h_eff), cfg.mode);
    assign xm    = rbf_pkg::map_index(xv, CRD'(w_eff), cfg.mode);
    assign status.scan_last = (dy_reg == r_pos) && (dx_reg == r_pos);

    assign in_col_x = CRD'(in_col_reg);
    assign in_row_x = CRD'(in_row_reg);
    assign wr_addr  = {in_row_x[ROW_BITS-1:0], in_col_x[COL_BITS-1:0]};
    assign rd_addr  = {ym.idx[ROW_BITS-1:0], xm.idx[COL_BITS-1:0]};

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            dy_reg <= r_neg;
            dx_reg <= r_neg;
        end
        else if (cmd.scan_run)
        begin
            if (dx_reg == r_pos)
            begin
                dx_reg <= r_neg;
                dy_reg <= dy_reg + DLT'(1);
            end
            else
            begin
                dx_reg <= dx_reg + DLT'(1);
            end
        end
    end

    // line store
    logic [rbf_pkg::PIX_BITS-1:0] mem [DEPTH];
    logic [rbf_pkg::PIX_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && pixel_wr)
        begin
            mem[wr_addr] <= {red_in, green_in, blue_in};
        end
        rd_data_reg <= mem[rd_addr];
    end

    logic rd_vld_reg, rd_keep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            rd_keep_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= cmd.scan_run;
            rd_keep_reg <= ym.keep && xm.keep;
        end
    end

    // per channel accumulate and divide
    logic [SUMB-1:0]   acc_reg [3];
    logic [DVD-1:0]    dvd_reg [3];
    logic [AREB-1:0]   rem_reg [3];
    logic [CNT-1:0]    cnt_reg;
    logic [CH-1:0]     chan [3];

    assign chan[0] = rd_data_reg[3*CH-1:2*CH];
    assign chan[1] = rd_data_reg[2*CH-1:CH];
    assign chan[2] = rd_data_reg[CH-1:0];
    assign status.div_last = (cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            cnt_reg <= CNT'(DVD - 1);
        end
        else if (cmd.div_run)
        begin
            cnt_reg <= cnt_reg - CNT'(1);
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        logic [AREB:0] rem_s;
        assign rem_s = {rem_reg[c], dvd_reg[c][DVD-1]};

        always_ff @(posedge clk)
        begin
            if (cmd.accept)
            begin
                acc_reg[c] <= '0;
            end
            else if (rd_vld_reg && rd_keep_reg)
            begin
                acc_reg[c] <= acc_reg[c] + SUMB'(chan[c]);
            end
            if (cmd.div_load)
            begin
                dvd_reg[c] <= {acc_reg[c], 8'd0} + DVD'(area >> 1);
                rem_reg[c] <= '0;
            end
            else if (cmd.div_run)
            begin
                if (rem_s >= {1'b0, area})
                begin
                    rem_reg[c] <= AREB'(rem_s - {1'b0, area});
                    dvd_reg[c] <= {dvd_reg[c][DVD-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[c] <= rem_s[AREB-1:0];
                    dvd_reg[c] <= {dvd_reg[c][DVD-2:0], 1'b0};
                end
            end
        end
    end

    assign red_mean   = dvd_reg[0][rbf_pkg::MEAN_BITS-1:0];
    assign green_mean = dvd_reg[1][rbf_pkg::MEAN_BITS-1:0];
    assign blue_mean  = dvd_reg[2][rbf_pkg::MEAN_BITS-1:0];
    assign out_column = oc_reg[rbf_pkg::OPOS_BITS-1:0];
    assign out_row    = or_reg[rbf_pkg::OPOS_BITS-1:0];
    assign frame_last = last;

endmodule

### rtl/rgb_box_filter.sv
// top level of the rgb box mean filter: config port, sequencer, datapath
// depends on rbf_pkg, rbf_cfg, rbf_ctrl, rbf_datapath
//
//   channel   handshake            payload
//   config    psel/penable/pready  paddr, pwdata, prdata
//   input     in_valid/in_stall    command, red_in, green_in, blue_in
//   output    out_valid/out_stall  red_mean, green_mean, blue_mean,
//                                  out_column, out_row, frame_last
//
// a request that yields no result leaves the sequencer idle, ready for the next
// a request with a result: scan, flush, load, divide, then output until taken:
//   one line store read per window sample, then a 28 step restoring divide
// reset clears the sequencer, position counters and config registers; the line
//   store needs no clearing
// after a request that yields a result, in_stall stays high from the cycle
//   after the accepting edge until the result is taken
module rgb_box_filter #(
    parameter int MAX_WIDTH  = rbf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rbf_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS = rbf_pkg::MAX_RADIUS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rbf_pkg::PADDR_BITS-1:0] paddr,
    input  logic [rbf_pkg::PDATA_BITS-1:0] pwdata,
    output logic [rbf_pkg::PDATA_BITS-1:0] prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           command,
    input  logic [rbf_pkg::CHAN_BITS-1:0]  red_in,
    input  logic [rbf_pkg::CHAN_BITS-1:0]  green_in,
    input  logic [rbf_pkg::CHAN_BITS-1:0]  blue_in,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rbf_pkg::MEAN_BITS-1:0]  red_mean,
    output logic [rbf_pkg::MEAN_BITS-1:0]  green_mean,
    output logic [rbf_pkg::MEAN_BITS-1:0]  blue_mean,
    output logic [rbf_pkg::OPOS_BITS-1:0]  out_column,
    output logic [rbf_pkg::OPOS_BITS-1:0]  out_row,
    output logic                           frame_last
);

    rbf_pkg::cfg_t    cfg;
    rbf_pkg::cmd_t    cmd;
    rbf_pkg::status_t status;
    logic             restart;

    // register writes also restart the frame
    rbf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .restart (restart)
    );

    rbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    rbf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .restart    (restart),
        .cmd        (cmd),
        .status     (status),
        .command    (command),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .red_mean   (red_mean),
        .green_mean (green_mean),
        .blue_mean  (blue_mean),
        .out_column (out_column),
        .out_row    (out_row),
        .frame_last (frame_last)
    );

endmodule

### test/tb_rgb_box_filter.sv
`timescale 1ns / 100ps
// self-checking testbench for rgb_box_filter: directed plan, size extremes, then random frames
// depends on rbf_pkg and the rgb_box_filter rtl; predicts every mean locally
module tb_rgb_box_filter;

    localparam logic CMD_DRAIN   = 1'b1;
    localparam int   STORE_DEPTH = (2 * rbf_pkg::MAX_RADIUS_DEF + 1) * rbf_pkg::MAX_WIDTH_DEF;
    // worst request: 33x33 window reads plus the divide, with slack
    localparam int   SETTLE      = 1200;
    localparam int   IDLE_LIMIT  = 20000;
    localparam int   HOLD_CYCLES = 2500;
    localparam int   EDGE_ITEMS  = 150;

    typedef struct packed {
        logic [rbf_pkg::MEAN_BITS-1:0] red;
        logic [rbf_pkg::MEAN_BITS-1:0] green;
        logic [rbf_pkg::MEAN_BITS-1:0] blue;
        logic [rbf_pkg::OPOS_BITS-1:0] col;
        logic [rbf_pkg::OPOS_BITS-1:0] row;
        logic                          last;
    } mean_t;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [31:0] val;
        logic        cmd;
        logic [7:0]  r, g, b;
        bit          typed;
        mean_t       want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [rbf_pkg::PADDR_BITS-1:0] paddr;
    logic [rbf_pkg::PDATA_BITS-1:0] pwdata;
    logic [rbf_pkg::PDATA_BITS-1:0] prdata;
    logic pready;
    logic in_valid, in_stall, command;
    logic [rbf_pkg::CHAN_BITS-1:0] red_in, green_in, blue_in;
    logic out_valid, out_stall;
    logic [rbf_pkg::MEAN_BITS-1:0] red_mean, green_mean, blue_mean;
    logic [rbf_pkg::OPOS_BITS-1:0] out_column, out_row;
    logic frame_last;

    rgb_box_filter dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .command(command),
        .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .red_mean(red_mean), .green_mean(green_mean), .blue_mean(blue_mean),
        .out_column(out_column), .out_row(out_row), .frame_last(frame_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // local model of the filter: register mirror, positions, pixel ring
    // ---------------------------------------------------------------
    logic [23:0]                   pix_ring [STORE_DEPTH];
    logic [rbf_pkg::DIM_BITS-1:0]  reg_w, reg_h;
    logic [rbf_pkg::RAD_BITS-1:0]  reg_r;
    logic [rbf_pkg::MODE_BITS-1:0] reg_m;
    int unsigned in_col, in_row, out_col, out_row_n;

    mean_t pending_means[$];
    int    fail_count = 0;
    bit    sender_calm = 0, sink_calm = 0, hold_req = 0;

    function automatic int unsigned eff_w();
        return (reg_w < 1) ? 1 : (reg_w > rbf_pkg::MAX_WIDTH_DEF ? rbf_pkg::MAX_WIDTH_DEF : reg_w);
    endfunction

    function automatic int unsigned eff_h();
        return (reg_h < 1) ? 1
                           : (reg_h > rbf_pkg::MAX_HEIGHT_DEF ? rbf_pkg::MAX_HEIGHT_DEF : reg_h);
    endfunction

    function automatic int unsigned eff_r();
        return (reg_r > rbf_pkg::MAX_RADIUS_DEF) ? rbf_pkg::MAX_RADIUS_DEF : reg_r;
    endfunction

    // border rule; returns 0 when a zero-fill sample drops out
    function automatic bit border_pos(input int v, input int n, output int idx);
        int t;
        t = v;
        idx = v;
        if (v >= 0 && v < n) return 1;
        if (reg_m == rbf_pkg::MODE_ZERO) return 0;
        if (reg_m == rbf_pkg::MODE_REFLECT)
            t = (v < 0) ? -v : 2 * (n - 1) - v;
        if (t < 0) t = 0;
        if (t > n - 1) t = n - 1;
        idx = t;
        return 1;
    endfunction

    function automatic mean_t window_mean(input int unsigned w, input int unsigned h,
                                          input int unsigned r);
        int unsigned sr, sg, sb, area;
        int          y, x, dy, dx;
        logic [23:0] px;
        mean_t       m;
        sr = 0; sg = 0; sb = 0;
        area = (2 * r + 1) * (2 * r + 1);
        for (dy = -int'(r); dy <= int'(r); dy++)
        begin
            if (!border_pos(int'(out_row_n) + dy, h, y)) continue;
            for (dx = -int'(r); dx <= int'(r); dx++)
            begin
                if (!border_pos(int'(out_col) + dx, w, x)) continue;
                px = pix_ring[(y * w + x) % STORE_DEPTH];
                sr += px[23:16];
                sg += px[15:8];
                sb += px[7:0];
            end
        end
        m.red   = 16'((sr * 256 + area / 2) / area);
        m.green = 16'((sg * 256 + area / 2) / area);
        m.blue  = 16'((sb * 256 + area / 2) / area);
        m.col   = 10'(out_col);
        m.row   = 10'(out_row_n);
        m.last  = (out_row_n + 1 >= h) && (out_col + 1 >= w);
        if (m.last)
        begin
            in_col = 0; in_row = 0; out_col = 0; out_row_n = 0;
        end
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row_n++;
            end
        end
        return m;
    endfunction

    // one accepted request; returns 1 when a mean comes out of it
    function automatic bit filter_step(input logic cmd, input logic [7:0] r,
                                       input logic [7:0] g, input logic [7:0] b,
                                       output mean_t m);
        int unsigned w, h, rad, p, q;
        w = eff_w(); h = eff_h(); rad = eff_r();
        if (cmd == rbf_pkg::CMD_PIXEL && in_row < h)
        begin
            p = in_row * w + in_col;
            q = out_row_n * w + out_col;
            pix_ring[p % STORE_DEPTH] = {r, g, b};
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
            if (out_row_n < h && q + rad * w + rad <= p)
            begin
                m = window_mean(w, h, rad);
                return 1;
            end
            return 0;
        end
        if (in_row >= h && out_row_n < h)
        begin
            m = window_mean(w, h, rad);
            return 1;
        end
        return 0;
    endfunction

    // ---------------------------------------------------------------
    // idle lengths: mostly none or short, now and then long
    // ---------------------------------------------------------------
    function automatic int pick_gap(input bit calm);
        int d;
        if (calm) return 0;
        d = $urandom_range(0, 99);
        if (d < 65) return 0;
        if (d < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // output side: random stall, plus one long hold-off on request
    int sink_wait = 0;
    int hold_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            sink_wait <= 0;
            hold_left <= 0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req)
        begin
            hold_req  = 0;
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (sink_wait > 0)
        begin
            out_stall <= 1'b1;
            sink_wait <= sink_wait - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            sink_wait <= pick_gap(sink_calm);
        end
    end

    // compare every taken mean with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_means.size() == 0)
            begin
                $error("unexpected mean at col %0d row %0d", out_column, out_row);
                fail_count++;
            end
            else
            begin
                mean_t w;
                w = pending_means.pop_front();
                if (red_mean !== w.red)
                begin
                    $error("red_mean exp %h got %h", w.red, red_mean);
                    fail_count++;
                end
                if (green_mean !== w.green)
                begin
                    $error("green_mean exp %h got %h", w.green, green_mean);
                    fail_count++;
                end
                if (blue_mean !== w.blue)
                begin
                    $error("blue_mean exp %h got %h", w.blue, blue_mean);
                    fail_count++;
                end
                if (out_column !== w.col)
                begin
                    $error("out_column exp %0d got %0d", w.col, out_column);
                    fail_count++;
                end
                if (out_row !== w.row)
                begin
                    $error("out_row exp %0d got %0d", w.row, out_row);
                    fail_count++;
                end
                if (frame_last !== w.last)
                begin
                    $error("frame_last exp %b got %b", w.last, frame_last);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: too long without any request or mean moving
    int quiet = 0;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // request driver; the previous request may have left in_valid high
    // ---------------------------------------------------------------
    int sent = 0;

    task automatic send_req(input logic cmd, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input bit typed, input mean_t want);
        int    d;
        mean_t m;
        d = pick_gap(sender_calm);
        if (d > 0)
        begin
            in_valid <= 1'b0;
            repeat (d) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (filter_step(cmd, r, g, b, m))
            pending_means.push_back(typed ? want : m);
        sent++;
    endtask

    task automatic send_rand(input logic cmd);
        send_req(cmd, 8'($urandom), 8'($urandom), 8'($urandom), 0, '0);
    endtask

    // sender pause until every mean has come, then let the block settle
    task automatic drain_all();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_means.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        drain_all();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            rbf_pkg::REG_WIDTH:  reg_w = val[rbf_pkg::DIM_BITS-1:0];
            rbf_pkg::REG_HEIGHT: reg_h = val[rbf_pkg::DIM_BITS-1:0];
            rbf_pkg::REG_RADIUS: reg_r = val[rbf_pkg::RAD_BITS-1:0];
            default:             reg_m = val[rbf_pkg::MODE_BITS-1:0];
        endcase
        in_col = 0; in_row = 0; out_col = 0; out_row_n = 0;
    endtask

    task automatic set_frame(input int w, input int h, input int r, input int mode);
        reg_write(rbf_pkg::REG_WIDTH, w);
        reg_write(rbf_pkg::REG_HEIGHT, h);
        reg_write(rbf_pkg::REG_RADIUS, r);
        reg_write(rbf_pkg::REG_MODE, mode);
    endtask

    // one frame of random pixels; noise adds ignored drain ticks, broken
    // frames stop early, and some flush requests are stray pixels
    task automatic send_frame(input bit noisy, input bit broken);
        int unsigned n, i, stop;
        n = eff_w() * eff_h();
        stop = broken ? $urandom_range(0, n) : n;
        for (i = 0; i < stop; i++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_rand(CMD_DRAIN);
            send_rand(rbf_pkg::CMD_PIXEL);
        end
        if (broken) return;
        // flush until the frame closes and every position is back at zero
        while (in_col != 0 || in_row != 0 || out_col != 0 || out_row_n != 0)
            send_rand(($urandom_range(0, 4) == 0) ? rbf_pkg::CMD_PIXEL : CMD_DRAIN);
        if (noisy)
            send_rand(CMD_DRAIN);
    endtask

    function automatic plan_row_t cfg_row(input logic [1:0] idx, input int val);
        plan_row_t p;
        p = '{default: '0};
        p.is_cfg = 1; p.idx = idx; p.val = val;
        return p;
    endfunction

    function automatic plan_row_t item_row(input logic cmd, input logic [7:0] r,
                                           input logic [7:0] g, input logic [7:0] b);
        plan_row_t p;
        p = '{default: '0};
        p.cmd = cmd; p.r = r; p.g = g; p.b = b;
        return p;
    endfunction

    function automatic plan_row_t typed_row(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b, input mean_t want);
        plan_row_t p;
        p = item_row(rbf_pkg::CMD_PIXEL, r, g, b);
        p.typed = 1; p.want = want;
        return p;
    endfunction

    plan_row_t plan[$];

    initial
    begin
        int ph, k;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        in_valid <= 1'b0;
        command  <= rbf_pkg::CMD_PIXEL;
        red_in   <= '0;
        green_in <= '0;
        blue_in  <= '0;
        reg_w = 512; reg_h = 512; reg_r = 3; reg_m = rbf_pkg::MODE_REFLECT;
        in_col = 0; in_row = 0; out_col = 0; out_row_n = 0;
        for (k = 0; k < STORE_DEPTH; k++) pix_ring[k] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed plan: single-pixel frames read off by eye, then a tiny frame
        plan.push_back(cfg_row(rbf_pkg::REG_WIDTH, 1));
        plan.push_back(cfg_row(rbf_pkg::REG_HEIGHT, 1));
        plan.push_back(cfg_row(rbf_pkg::REG_RADIUS, 0));
        plan.push_back(item_row(CMD_DRAIN, 0, 0, 0));     // drain with frame not in
        plan.push_back(typed_row(8'hff, 8'h00, 8'h80, '{16'hff00, 16'h0000, 16'h8000,
                                                       10'd0, 10'd0, 1'b1}));
        plan.push_back(item_row(CMD_DRAIN, 0, 0, 0));     // nothing pending
        plan.push_back(cfg_row(rbf_pkg::REG_RADIUS, 31)); // clamps to the max radius
        plan.push_back(cfg_row(rbf_pkg::REG_MODE, 3));    // unused mode acts as replicate
        plan.push_back(typed_row(8'hff, 8'hff, 8'hff, '{16'hff00, 16'hff00, 16'hff00,
                                                       10'd0, 10'd0, 1'b1}));
        plan.push_back(cfg_row(rbf_pkg::REG_MODE, rbf_pkg::MODE_REFLECT)); // reflect then clamp
        plan.push_back(typed_row(8'h12, 8'h34, 8'h56, '{16'h1200, 16'h3400, 16'h5600,
                                                       10'd0, 10'd0, 1'b1}));
        plan.push_back(cfg_row(rbf_pkg::REG_MODE, rbf_pkg::MODE_ZERO));
        plan.push_back(item_row(rbf_pkg::CMD_PIXEL, 8'hff, 8'h00, 8'h01));
        plan.push_back(cfg_row(rbf_pkg::REG_WIDTH, 0));   // clamps to one
        plan.push_back(cfg_row(rbf_pkg::REG_WIDTH, 3));
        plan.push_back(cfg_row(rbf_pkg::REG_HEIGHT, 2));
        plan.push_back(cfg_row(rbf_pkg::REG_RADIUS, 1));
        for (k = 0; k < 6; k++)
            plan.push_back(item_row(rbf_pkg::CMD_PIXEL, 8'(k * 51), 8'(255 - k * 40),
                                    8'(k * 7)));
        plan.push_back(item_row(rbf_pkg::CMD_PIXEL, 8'haa, 8'h55, 8'h0f)); // pixel after frame
        for (k = 0; k < 4; k++)
            plan.push_back(item_row(CMD_DRAIN, 0, 0, 0));

        sender_calm = 1; sink_calm = 1;
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                reg_write(plan[i].idx, plan[i].val);
            else
                send_req(plan[i].cmd, plan[i].r, plan[i].g, plan[i].b,
                         plan[i].typed, plan[i].want);
        end

        // extremes of the size registers: the start of the widest row and
        // of the tallest column; the next register write drops the rest
        sender_calm = 0; sink_calm = 0;
        set_frame(2047, 1, 0, $urandom_range(0, 3));
        for (k = 0; k < EDGE_ITEMS; k++) send_rand(rbf_pkg::CMD_PIXEL);
        set_frame(1, 2047, 1, $urandom_range(0, 3));
        for (k = 0; k < EDGE_ITEMS; k++) send_rand(rbf_pkg::CMD_PIXEL);

        // random frames, mostly small so the per-mean cost stays low
        ph = 0;
        while (sent < 800 || ph < 6)
        begin
            if ($urandom_range(0, 15) == 0)
                set_frame($urandom_range(1, 3), $urandom_range(1, 3), 16,
                          $urandom_range(0, 3));
            else
                set_frame($urandom_range(1, 12), $urandom_range(1, 8),
                          $urandom_range(0, 4), $urandom_range(0, 3));
            sender_calm = ($urandom_range(0, 5) == 0);
            sink_calm   = ($urandom_range(0, 5) == 0);
            if (ph == 3)
                hold_req = 1;   // output side holds off while requests keep coming
            send_frame(1, $urandom_range(0, 9) == 0);
            if (ph == 5)
            begin
                // pause mid-frame until everything predicted has come out
                for (k = 0; k < int'(eff_w()); k++) send_rand(rbf_pkg::CMD_PIXEL);
                drain_all();
                send_frame(1, 0);
            end
            else if ($urandom_range(0, 2) == 0)
                send_frame(1, 0);   // back to back frames on the same settings
            ph++;
        end

        drain_all();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
